// ===== hdl/tbra_pkg.sv =====
`default_nettype none
package tbra_pkg;

    // Design constants
    localparam int unsigned BYTES_PER_PIXEL = 4;
    localparam int unsigned MAX_TILE_HEIGHT = 64;

    // Divider layout: 16-bit quotient, a few restoring steps per stage
    localparam int unsigned DIV_BITS        = 16;
    localparam int unsigned DIV_STEPS_STAGE = 4;
    localparam int unsigned DIV_STAGES      = DIV_BITS / DIV_STEPS_STAGE;

    // Configuration register indexes
    localparam logic [2:0] CFG_IMAGE_BASE    = 3'd0;
    localparam logic [2:0] CFG_TILE_WIDTH    = 3'd1;
    localparam logic [2:0] CFG_TILE_HEIGHT   = 3'd2;
    localparam logic [2:0] CFG_TILE_SPACING  = 3'd3;
    localparam logic [2:0] CFG_ATLAS_COLUMNS = 3'd4;
    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd5;

    typedef struct packed {
        logic [31:0] image_base;
        logic [8:0]  tile_width;
        logic [6:0]  tile_height;
        logic [7:0]  tile_spacing;
        logic [8:0]  atlas_columns;
        logic [12:0] image_width;
    } t_cfg;

    // Item leaving the divider: quotient is tile row, remainder tile column
    typedef struct packed {
        logic        zero;
        logic [8:0]  rem;
        logic [15:0] dq;
        logic [31:0] dest_base;
        logic [12:0] dstride;
    } t_div_item;

    // Item leaving the address stages
    typedef struct packed {
        logic        zero;
        logic [31:0] src;
        logic [31:0] dest_base;
        logic [12:0] dstride;
    } t_addr_item;

endpackage
`default_nettype wire

// ===== hdl/tbra_div.sv =====
`default_nettype none
module tbra_div
    import tbra_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_tile_number,
    input  wire logic [31:0] i_dest_base,
    input  wire logic [12:0] i_dest_stride_px,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_div_item        o_item
);

    localparam int unsigned LAST = DIV_STAGES;

    logic      r_v   [0:LAST];
    t_div_item r_s   [0:LAST];
    logic      w_adv [0:LAST];
    logic [8:0] w_cols;

    // A few restoring division steps on the {remainder, dividend} pair
    function automatic t_div_item div_steps(t_div_item s, logic [8:0] d);
        logic [9:0] t;
        t_div_item  r;
        r = s;
        for (int i = 0; i < DIV_STEPS_STAGE; i++) begin
            t    = {r.rem, r.dq[DIV_BITS-1]};
            r.dq = {r.dq[DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                r.rem   = 9'(t - {1'b0, d});
                r.dq[0] = 1'b1;
            end else begin
                r.rem = t[8:0];
            end
        end
        return r;
    endfunction

    // zero columns count as one
    assign w_cols = (i_cfg.atlas_columns == 9'd0) ? 9'd1 : i_cfg.atlas_columns;

    // stage may load when empty or when its content moves on
    always_comb begin
        w_adv[LAST] = !r_v[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // payload: input capture, then division stages
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s[0].zero      <= (i_tile_number == 16'd0);
            r_s[0].rem       <= 9'd0;
            r_s[0].dq        <= i_tile_number - 16'd1;
            r_s[0].dest_base <= i_dest_base;
            r_s[0].dstride   <= i_dest_stride_px;
        end
        for (int k = 1; k <= LAST; k++) begin
            if (w_adv[k]) begin
                r_s[k] <= div_steps(r_s[k-1], w_cols);
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_v[LAST];
    assign o_item  = r_s[LAST];

endmodule
`default_nettype wire

// ===== hdl/tbra_addr.sv =====
`default_nettype none
module tbra_addr
    import tbra_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_div_item i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_addr_item     o_item
);

    typedef struct packed {
        logic        zero;
        logic [18:0] px;
        logic [24:0] py;
        logic [31:0] dest_base;
        logic [12:0] dstride;
    } t_a1;

    typedef struct packed {
        logic        zero;
        logic [18:0] px;
        logic [31:0] prod;
        logic [31:0] dest_base;
        logic [12:0] dstride;
    } t_a2;

    logic       r_v1, r_v2, r_v3;
    t_a1        r_a1;
    t_a2        r_a2;
    t_addr_item r_a3;
    logic       w_adv1, w_adv2, w_adv3;
    logic [9:0]  w_pitch_x;
    logic [8:0]  w_pitch_y;
    logic [31:0] w_prod;
    logic [31:0] w_start;

    assign w_adv3 = !r_v3 || i_ready;
    assign w_adv2 = !r_v2 || w_adv3;
    assign w_adv1 = !r_v1 || w_adv2;

    // tile pitch in pixels, both axes
    assign w_pitch_x = 10'(i_cfg.tile_width) + 10'(i_cfg.tile_spacing);
    assign w_pitch_y = 9'(i_cfg.tile_height) + 9'(i_cfg.tile_spacing);

    // row offset times source pitch, wraps at 32 bits
    assign w_prod  = 32'(r_a1.py) * 32'(i_cfg.image_width);
    assign w_start = r_a2.prod + 32'(r_a2.px);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
        end
    end

    // stage 1: pixel offsets of the tile corner
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_a1.zero      <= i_item.zero;
            r_a1.px        <= 19'(w_pitch_x) * 19'(i_item.rem);
            r_a1.py        <= 25'(w_pitch_y) * 25'(i_item.dq);
            r_a1.dest_base <= i_item.dest_base;
            r_a1.dstride   <= i_item.dstride;
        end
    end

    // stage 2: row offset times source pitch
    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_a2.zero      <= r_a1.zero;
            r_a2.px        <= r_a1.px;
            r_a2.prod      <= w_prod;
            r_a2.dest_base <= r_a1.dest_base;
            r_a2.dstride   <= r_a1.dstride;
        end
    end

    // stage 3: byte address of the first source row
    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_a3.zero      <= r_a2.zero;
            r_a3.src       <= i_cfg.image_base + 32'(w_start * BYTES_PER_PIXEL);
            r_a3.dest_base <= r_a2.dest_base;
            r_a3.dstride   <= r_a2.dstride;
        end
    end

    assign o_ready = w_adv1;
    assign o_valid = r_v3;
    assign o_item  = r_a3;

endmodule
`default_nettype wire

// ===== hdl/tbra_rows.sv =====
`default_nettype none
module tbra_rows
    import tbra_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_addr_item i_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [31:0]     o_src_address,
    output logic [31:0]     o_dest_address,
    output logic [11:0]     o_length_bytes,
    output logic            o_last_row,
    output logic            o_error
);

    logic        r_active;
    logic [6:0]  r_left;
    logic        r_err;
    logic [31:0] r_src;
    logic [31:0] r_dst;
    logic [31:0] r_dst_step;
    logic        r_out_valid;
    logic [31:0] r_o_src;
    logic [31:0] r_o_dst;
    logic [11:0] r_o_len;
    logic        r_o_last;
    logic        r_o_err;

    logic        w_fire;
    logic        w_last;
    logic        w_take;
    logic [6:0]  w_rows;
    logic [11:0] w_len;
    logic [31:0] w_src_step;
    logic        n_out_valid;

    // rows per tile, capped at the maximum height
    assign w_rows = (i_cfg.tile_height > 7'(MAX_TILE_HEIGHT)) ?
                    7'(MAX_TILE_HEIGHT) : i_cfg.tile_height;
    assign w_len      = 12'(i_cfg.tile_width * BYTES_PER_PIXEL);
    assign w_src_step = 32'(i_cfg.image_width * BYTES_PER_PIXEL);

    // emit a row when the output register is free or being drained
    assign w_fire = r_active && (!r_out_valid || i_out_ready);
    assign w_last = (r_left == 7'd1);
    assign w_take = i_valid && (!r_active || (w_fire && w_last));

    assign n_out_valid = w_fire ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_left      <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                if (i_item.zero) begin
                    r_active <= 1'b1;
                    r_left   <= 7'd1;
                end else begin
                    r_active <= (w_rows != 7'd0);
                    r_left   <= w_rows;
                end
            end else if (w_fire) begin
                r_left <= r_left - 7'd1;
                if (w_last) r_active <= 1'b0;
            end
        end
    end

    // row cursors
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_err      <= i_item.zero;
            r_src      <= i_item.zero ? 32'd0 : i_item.src;
            r_dst      <= i_item.zero ? 32'd0 : i_item.dest_base;
            r_dst_step <= 32'(i_item.dstride * BYTES_PER_PIXEL);
        end else if (w_fire) begin
            r_src <= r_src + w_src_step;
            r_dst <= r_dst + r_dst_step;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_o_src  <= r_src;
            r_o_dst  <= r_dst;
            r_o_len  <= r_err ? 12'd0 : w_len;
            r_o_last <= w_last;
            r_o_err  <= r_err;
        end
    end

    assign o_ready        = !r_active || (w_fire && w_last);
    assign o_out_valid    = r_out_valid;
    assign o_src_address  = r_o_src;
    assign o_dest_address = r_o_dst;
    assign o_length_bytes = r_o_len;
    assign o_last_row     = r_o_last;
    assign o_error        = r_o_err;

endmodule
`default_nettype wire

// ===== hdl/tile_blit_row_address_generator.sv =====
// A request passes the front end, then the row sequencer and its output register.
// Throughput: one row command per cycle while the sink is ready; a tile gives
// min(tile_height, 64) row commands, an error tile one, a zero-height tile none.
// Front end is an 8-stage pipeline (input, 4 divider stages, 3 address stages).
// Reset (synchronous, active low) empties the pipeline and loads config defaults.
`default_nettype none
module tile_blit_row_address_generator
    import tbra_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_tile_number,
    input  wire logic [31:0] i_dest_base,
    input  wire logic [12:0] i_dest_stride_px,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_src_address,
    output logic [31:0]      o_dest_address,
    output logic [11:0]      o_length_bytes,
    output logic             o_last_row,
    output logic             o_error
);

    t_cfg       r_cfg;
    logic       w_div_valid, w_div_ready;
    t_div_item  w_div_item;
    logic       w_addr_valid, w_addr_ready;
    t_addr_item w_addr_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_base    <= 32'd0;
            r_cfg.tile_width    <= 9'd16;
            r_cfg.tile_height   <= 7'd16;
            r_cfg.tile_spacing  <= 8'd0;
            r_cfg.atlas_columns <= 9'd16;
            r_cfg.image_width   <= 13'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_BASE:    r_cfg.image_base    <= i_cfg_data;
                CFG_TILE_WIDTH:    r_cfg.tile_width    <= i_cfg_data[8:0];
                CFG_TILE_HEIGHT:   r_cfg.tile_height   <= i_cfg_data[6:0];
                CFG_TILE_SPACING:  r_cfg.tile_spacing  <= i_cfg_data[7:0];
                CFG_ATLAS_COLUMNS: r_cfg.atlas_columns <= i_cfg_data[8:0];
                CFG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // tile number to atlas row and column
    tbra_div u_div (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_tile_number    (i_tile_number),
        .i_dest_base      (i_dest_base),
        .i_dest_stride_px (i_dest_stride_px),
        .o_valid          (w_div_valid),
        .i_ready          (w_div_ready),
        .o_item           (w_div_item)
    );

    // source start address
    tbra_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_div_valid),
        .o_ready (w_div_ready),
        .i_item  (w_div_item),
        .o_valid (w_addr_valid),
        .i_ready (w_addr_ready),
        .o_item  (w_addr_item)
    );

    // per-row command sequencer
    tbra_rows u_rows (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (w_addr_valid),
        .o_ready        (w_addr_ready),
        .i_item         (w_addr_item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_src_address  (o_src_address),
        .o_dest_address (o_dest_address),
        .o_length_bytes (o_length_bytes),
        .o_last_row     (o_last_row),
        .o_error        (o_error)
    );

endmodule
`default_nettype wire

// ===== bench/blit_row_checker.sv =====
`timescale 1ns / 100ps
module blit_row_checker
    import tbra_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [15:0] i_tile_number,
    input  wire logic [31:0] i_dest_base,
    input  wire logic [12:0] i_dest_stride_px,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_src_address,
    input  wire logic [31:0] i_dest_address,
    input  wire logic [11:0] i_length_bytes,
    input  wire logic        i_last_row,
    input  wire logic        i_error,
    output int               o_fail_count,
    output int               o_rows_pending
);

    typedef struct packed {
        logic [31:0] src_address;
        logic [31:0] dest_address;
        logic [11:0] length_bytes;
        logic        last_row;
        logic        error;
    } t_row_cmd;

    localparam t_cfg CFG_DEFAULTS = '{
        image_base:    32'd0,
        tile_width:    9'd16,
        tile_height:   7'd16,
        tile_spacing:  8'd0,
        atlas_columns: 9'd16,
        image_width:   13'd256
    };

    t_cfg     atlas_cfg = CFG_DEFAULTS;
    t_row_cmd row_cmds_due[$];

    // Queue one expected row command at the tail
    task automatic append_row_cmd(input t_row_cmd cmd);
        row_cmds_due.insert(row_cmds_due.size(), cmd);
    endtask

    // Work out every row command one tile request causes
    task automatic plan_tile_rows(input logic [15:0] tnum, input logic [31:0] dbase,
                                  input logic [12:0] dstride);
        logic [31:0] cols, idx, px, py, start, nrows, src_step, dst_step;
        logic [31:0] src_p, dst_p;
        logic [11:0] len;
        t_row_cmd    cmd;
        if (tnum == 16'd0) begin
            // invalid tile: single flagged command, no copy
            cmd = '{src_address: 32'd0, dest_address: 32'd0, length_bytes: 12'd0,
                    last_row: 1'b1, error: 1'b1};
            append_row_cmd(cmd);
        end else begin
            cols     = (atlas_cfg.atlas_columns == 9'd0) ? 32'd1
                                                         : 32'(atlas_cfg.atlas_columns);
            idx      = 32'(tnum) - 32'd1;
            px       = (32'(atlas_cfg.tile_width) + 32'(atlas_cfg.tile_spacing))
                       * (idx % cols);
            py       = (32'(atlas_cfg.tile_height) + 32'(atlas_cfg.tile_spacing))
                       * (idx / cols);
            start    = py * 32'(atlas_cfg.image_width) + px;
            nrows    = (32'(atlas_cfg.tile_height) > MAX_TILE_HEIGHT)
                       ? 32'(MAX_TILE_HEIGHT) : 32'(atlas_cfg.tile_height);
            len      = 12'(32'(atlas_cfg.tile_width) * BYTES_PER_PIXEL);
            src_step = 32'(atlas_cfg.image_width) * BYTES_PER_PIXEL;
            dst_step = 32'(dstride) * BYTES_PER_PIXEL;
            src_p    = atlas_cfg.image_base + start * BYTES_PER_PIXEL;
            dst_p    = dbase;
            for (int k = 0; k < int'(nrows); k++) begin
                cmd = '{src_address: src_p, dest_address: dst_p, length_bytes: len,
                        last_row: (32'(k) + 32'd1 == nrows), error: 1'b0};
                append_row_cmd(cmd);
                src_p = src_p + src_step;
                dst_p = dst_p + dst_step;
            end
        end
    endtask

    // Track config, predict on request transactions, compare on row transactions
    always @(posedge i_clk) begin : watch_channels
        t_row_cmd due;
        if (!i_rst_n) begin
            atlas_cfg = CFG_DEFAULTS;
            row_cmds_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_BASE:    atlas_cfg.image_base    = i_cfg_data;
                    CFG_TILE_WIDTH:    atlas_cfg.tile_width    = i_cfg_data[8:0];
                    CFG_TILE_HEIGHT:   atlas_cfg.tile_height   = i_cfg_data[6:0];
                    CFG_TILE_SPACING:  atlas_cfg.tile_spacing  = i_cfg_data[7:0];
                    CFG_ATLAS_COLUMNS: atlas_cfg.atlas_columns = i_cfg_data[8:0];
                    CFG_IMAGE_WIDTH:   atlas_cfg.image_width   = i_cfg_data[12:0];
                    default: ;  // unused index, no effect
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (row_cmds_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected row cmd: src=%h dst=%h len=%0d last=%b err=%b",
                                 i_src_address, i_dest_address, i_length_bytes,
                                 i_last_row, i_error);
                    o_fail_count++;
                end else begin
                    due = row_cmds_due.pop_front();
                    if (due.src_address !== i_src_address
                        || due.dest_address !== i_dest_address
                        || due.length_bytes !== i_length_bytes
                        || due.last_row !== i_last_row
                        || due.error !== i_error) begin
                        if (o_fail_count < 10) begin
                            $display("row cmd mismatch: exp src=%h dst=%h len=%0d last=%b err=%b",
                                     due.src_address, due.dest_address, due.length_bytes,
                                     due.last_row, due.error);
                            $display("                  got src=%h dst=%h len=%0d last=%b err=%b",
                                     i_src_address, i_dest_address, i_length_bytes,
                                     i_last_row, i_error);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                plan_tile_rows(i_tile_number, i_dest_base, i_dest_stride_px);
        end
        o_rows_pending = row_cmds_due.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import tbra_pkg::*;

    localparam int          CYCLE_LIMIT    = 300000;
    localparam int          DRAIN_CYCLES   = 32;
    localparam int          RAND_PHASES    = 8;
    localparam int          RAND_PER_PH    = 14;
    localparam int          DIRECTED_ITEMS = 18;
    // long hold-off starts right after the first request of this phase
    localparam int          HOLD_PHASE     = 6;
    localparam int          HOLD_AT        = DIRECTED_ITEMS + HOLD_PHASE * RAND_PER_PH + 1;
    localparam int          HOLD_CYCLES    = 700;
    // unused register slots
    localparam logic [2:0]  CFG_SPARE_LO   = 3'd6;
    localparam logic [2:0]  CFG_SPARE_HI   = 3'd7;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_valid      = 1'b0;
    logic [2:0]  i_cfg_index      = '0;
    logic [31:0] i_cfg_data       = '0;
    logic        i_in_valid       = 1'b0;
    logic [15:0] i_tile_number    = '0;
    logic [31:0] i_dest_base      = '0;
    logic [12:0] i_dest_stride_px = '0;
    logic        i_out_ready      = 1'b0;
    logic        o_cfg_ready, o_in_ready, o_out_valid, o_last_row, o_error;
    logic [31:0] o_src_address, o_dest_address;
    logic [11:0] o_length_bytes;

    int          fail_count, rows_pending;
    int          n_sent      = 0;
    int          cycle_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;

    tile_blit_row_address_generator i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_tile_number    (i_tile_number),
        .i_dest_base      (i_dest_base),
        .i_dest_stride_px (i_dest_stride_px),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_src_address    (o_src_address),
        .o_dest_address   (o_dest_address),
        .o_length_bytes   (o_length_bytes),
        .o_last_row       (o_last_row),
        .o_error          (o_error)
    );

    blit_row_checker u_row_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_tile_number    (i_tile_number),
        .i_dest_base      (i_dest_base),
        .i_dest_stride_px (i_dest_stride_px),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_src_address    (o_src_address),
        .i_dest_address   (o_dest_address),
        .i_length_bytes   (o_length_bytes),
        .i_last_row       (o_last_row),
        .i_error          (o_error),
        .o_fail_count     (fail_count),
        .o_rows_pending   (rows_pending)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Row command sink: random stalls, plus one long hold-off to back up the pipe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && n_sent >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Zero, all ones, or a value from the usual range
    function automatic logic [31:0] pick_field(int unsigned bits, int unsigned lo,
                                               int unsigned hi);
        logic [63:0] ones;
        int unsigned r;
        ones = (64'd1 << bits) - 64'd1;
        r    = $urandom_range(9);
        if (r == 0)
            return 32'd0;
        else if (r == 1)
            return ones[31:0];
        else
            return $urandom_range(hi, lo);
    endfunction

    // Wait until every row command is out and any row-less tiles have drained
    task automatic wait_drained();
        @(posedge i_clk);
        while (rows_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write transaction; valid is left high for back-to-back writes
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_regs(input t_cfg c, input bit poke_spare);
        wait_drained();
        write_reg(CFG_IMAGE_BASE,    c.image_base);
        write_reg(CFG_TILE_WIDTH,    32'(c.tile_width));
        write_reg(CFG_TILE_HEIGHT,   32'(c.tile_height));
        write_reg(CFG_TILE_SPACING,  32'(c.tile_spacing));
        write_reg(CFG_ATLAS_COLUMNS, 32'(c.atlas_columns));
        write_reg(CFG_IMAGE_WIDTH,   32'(c.image_width));
        if (poke_spare)
            write_reg(($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // One tile request transaction, with an optional idle gap in front
    task automatic offer_tile(input logic [15:0] tnum, input logic [31:0] dbase,
                              input logic [12:0] dstride);
        if (n_sent < 50) begin
            tx_idle_pct = 23;
            rx_idle_pct = 52;
        end else if (n_sent < 100) begin
            tx_idle_pct = 52;
            rx_idle_pct = 23;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid       <= 1'b1;
        i_tile_number    <= tnum;
        i_dest_base      <= dbase;
        i_dest_stride_px <= dstride;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    function automatic t_cfg roll_cfg();
        t_cfg c;
        c.image_base    = pick_field(32, 0, 32'hFFFF_FFFF);
        c.tile_width    = 9'(pick_field(9, 1, 32));
        c.tile_height   = 7'(pick_field(7, 1, 24));
        c.tile_spacing  = 8'(pick_field(8, 0, 8));
        c.atlas_columns = 9'(pick_field(9, 1, 32));
        c.image_width   = 13'(pick_field(13, 64, 2048));
        return c;
    endfunction

    initial begin : stimulus
        logic [15:0] tnum;
        logic [12:0] stride;
        int unsigned r;
        t_cfg        ph_cfg;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset defaults, error tile, field extremes, address wrap
        offer_tile(16'd0, 32'h1234_5678, 13'd16);
        offer_tile(16'd1, 32'd0, 13'd1);
        offer_tile(16'hFFFF, 32'hFFFF_FFFF, 13'h1FFF);
        offer_tile(16'd16, 32'h8000_0000, 13'd4096);
        offer_tile(16'd17, 32'h0000_1000, 13'd0);   // zero stride: dest repeats
        i_in_valid <= 1'b0;

        // Zero columns, oversize width and height, max spacing, wrapping base
        program_regs('{image_base: 32'hFFFF_FFF0, tile_width: 9'd511, tile_height: 7'd127,
                       tile_spacing: 8'd255, atlas_columns: 9'd0,
                       image_width: 13'h1FFF}, 1'b0);
        offer_tile(16'd1, 32'hFFFF_FF00, 13'd4096);
        offer_tile(16'd2, 32'h0000_0004, 13'd8);
        offer_tile(16'hFFFF, 32'h5555_5555, 13'h0AAA);
        offer_tile(16'd0, 32'hFFFF_FFFF, 13'h1FFF);
        i_in_valid <= 1'b0;

        // Zero height (no rows), zero width, zero image width
        program_regs('{image_base: 32'h0000_0100, tile_width: 9'd0, tile_height: 7'd0,
                       tile_spacing: 8'd3, atlas_columns: 9'd1,
                       image_width: 13'd0}, 1'b1);
        offer_tile(16'd5, 32'h0000_2000, 13'd32);
        offer_tile(16'd0, 32'h0000_3000, 13'd32);
        offer_tile(16'd3, 32'h0000_4000, 13'd32);
        i_in_valid <= 1'b0;

        // Single row, max legal width and columns; spare indexes must be ignored
        program_regs('{image_base: 32'd0, tile_width: 9'd256, tile_height: 7'd1,
                       tile_spacing: 8'd0, atlas_columns: 9'd256,
                       image_width: 13'd4096}, 1'b1);
        @(posedge i_clk);
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h0000_0000);
        i_cfg_valid <= 1'b0;
        offer_tile(16'd256, 32'h1000_0000, 13'd4096);
        offer_tile(16'd257, 32'h2000_0000, 13'd1);
        offer_tile(16'hFFFF, 32'hAAAA_AAAA, 13'h1555);
        i_in_valid <= 1'b0;

        // Full-height tile, one-pixel width, 9-bit column count
        program_regs('{image_base: 32'h0FF0_0000, tile_width: 9'd1, tile_height: 7'd64,
                       tile_spacing: 8'd1, atlas_columns: 9'd511,
                       image_width: 13'd1}, 1'b0);
        offer_tile(16'd1000, 32'h0000_0000, 13'd1);
        offer_tile(16'hAAAA, 32'hCAFE_0000, 13'd4096);
        offer_tile(16'h5555, 32'h0000_0010, 13'd0);
        i_in_valid <= 1'b0;

        // Random phases, each under a fresh register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            ph_cfg = roll_cfg();
            // the hold-off phase needs rows so that the pipe backs up
            if (ph == HOLD_PHASE && ph_cfg.tile_height == 7'd0)
                ph_cfg.tile_height = 7'd16;
            program_regs(ph_cfg, ($urandom_range(3) == 0));
            for (int n = 0; n < RAND_PER_PH; n++) begin
                r = $urandom_range(9);
                if (r == 0)
                    tnum = 16'd0;
                else if (r == 1)
                    tnum = 16'($urandom_range(16'hFFFF));
                else
                    tnum = 16'($urandom_range(64, 1));
                r = $urandom_range(9);
                if (r == 0)
                    stride = 13'd0;
                else if (r == 1)
                    stride = 13'($urandom_range(13'h1FFF));
                else
                    stride = 13'($urandom_range(512, 1));
                offer_tile(tnum, $urandom, stride);
            end
            i_in_valid <= 1'b0;
        end

        wait_drained();
        if (fail_count == 0 && rows_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
